[hdl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/evrts_pkg.sv]
package evrts_pkg;

	localparam int NUM_VOICES = 8;

	localparam logic [2:0] KIND_TICK     = 3'd0;
	localparam logic [2:0] KIND_PAD      = 3'd1;
	localparam logic [2:0] KIND_PAGE     = 3'd2;
	localparam logic [2:0] KIND_LATCH    = 3'd3;
	localparam logic [2:0] KIND_INACTIVE = 3'd4;

	localparam logic [1:0] PAGE_PLAY   = 2'd0;
	localparam logic [1:0] PAGE_RHYTHM = 2'd1;
	localparam logic [1:0] PAGE_LENGTH = 2'd2;

	localparam logic [6:0] DIVIDE_MAX = 7'd64;

	// rhythm 0 in the low byte, bit s is step s
	localparam logic [7:0][7:0] DEFAULT_RHYTHMS = {
		8'h1B, 8'hD9, 8'hA5, 8'h23, 8'h21, 8'hCB, 8'h19, 8'hC9
	};

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] pad_row;
		logic [2:0] pad_column;
		logic       pad_pressed;
		logic [1:0] page_choice;
	} item_t;

	typedef struct packed {
		logic [7:0] trigger_mask;
		logic       step_taken;
		logic       latch_on;
	} result_t;

endpackage

[hdl/evrts_core.sv]
`include "assert_macros.svh"

module evrts_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	input  logic               advance,
	input  evrts_pkg::item_t   item,
	output evrts_pkg::result_t result
);

	logic [6:0]      clock_divide_q;
	logic [5:0]      div_count_q, div_count_d;
	logic [7:0][7:0] bits_q, bits_d;
	logic [7:0][3:0] len_q, len_d;
	logic [7:0]      running_q, running_d;
	logic [7:0]      armed_q, armed_d;
	logic [7:0][2:0] rhythm_q, rhythm_d;
	logic [7:0][2:0] pos_q, pos_d;
	logic [7:0][2:0] pending_q, pending_d;
	logic [63:0]     pads_q, pads_d;
	logic            latch_q, latch_d;
	logic [1:0]      page_q, page_d;
	logic [6:0]      div_eff;

	// advance modulo the rhythm length, a stale position may need several wraps
	function automatic logic [2:0] wrap_step(input logic [2:0] pos, input logic [3:0] len);
		logic [3:0] r;
		logic [3:0] l;
		l = (len == 4'd0) ? 4'd1 : len;
		r = {1'b0, pos} + 4'd1;
		for (int i = 0; i < 8; i++) begin
			if (r >= l) begin
				r = r - l;
			end
		end
		return r[2:0];
	endfunction

	always_comb begin
		if (clock_divide_q == 7'd0) begin
			div_eff = 7'd1;
		end else if (clock_divide_q > evrts_pkg::DIVIDE_MAX) begin
			div_eff = evrts_pkg::DIVIDE_MAX;
		end else begin
			div_eff = clock_divide_q;
		end
	end

	always_comb begin
		logic       run;
		logic [2:0] rhy;
		logic [2:0] pos;
		logic [6:0] cnt_inc;
		logic [3:0] new_len;
		logic       col_held;
		logic [2:0] col;
		logic [2:0] row;
		logic [5:0] idx;
		div_count_d = div_count_q;
		bits_d      = bits_q;
		len_d       = len_q;
		running_d   = running_q;
		armed_d     = armed_q;
		rhythm_d    = rhythm_q;
		pos_d       = pos_q;
		pending_d   = pending_q;
		pads_d      = pads_q;
		latch_d     = latch_q;
		page_d      = page_q;
		result      = '0;
		run         = 1'b0;
		rhy         = '0;
		pos         = '0;
		col         = item.pad_column;
		row         = item.pad_row;
		idx         = {row, col};
		cnt_inc     = {1'b0, div_count_q} + 7'd1;
		col_held    = 1'b0;
		new_len     = 4'd8 - {1'b0, row};
		if (advance) begin
			unique case (item.kind)
				evrts_pkg::KIND_TICK: begin
					if (cnt_inc < div_eff) begin
						div_count_d = cnt_inc[5:0];
					end else begin
						div_count_d = '0;
						result.step_taken = 1'b1;
						for (int v = 0; v < evrts_pkg::NUM_VOICES; v++) begin
							run = running_q[v];
							rhy = rhythm_q[v];
							pos = pos_q[v];
							if (armed_q[v]) begin
								run = 1'b1;
								rhy = pending_q[v];
								pos = 3'd0;
								armed_d[v]   = 1'b0;
								running_d[v] = 1'b1;
								rhythm_d[v]  = rhy;
							end
							if (run) begin
								result.trigger_mask[v] = bits_q[rhy][pos];
								pos_d[v] = wrap_step(pos, len_q[rhy]);
							end
						end
					end
				end
				evrts_pkg::KIND_PAD: begin
					if (!latch_q && !item.pad_pressed && pads_q[idx]) begin
						pads_d[idx] = 1'b0;
						for (int r = 0; r < 8; r++) begin
							col_held = col_held | pads_d[{3'(r), col}];
						end
						if (!col_held) begin
							running_d[col] = 1'b0;
							armed_d[col]   = 1'b0;
							pos_d[col]     = 3'd0;
						end
					end else if (item.pad_pressed) begin
						case (page_q)
							evrts_pkg::PAGE_PLAY: begin
								if (latch_q) begin
									if (!running_q[col] && !armed_q[col]) begin
										pending_d[col] = row;
										armed_d[col]   = 1'b1;
									end else if (armed_q[col]) begin
										if (pending_q[col] == row) begin
											armed_d[col] = 1'b0;
										end else begin
											pending_d[col] = row;
										end
									end else if (rhythm_q[col] == row) begin
										running_d[col] = 1'b0;
										pos_d[col]     = 3'd0;
									end else begin
										rhythm_d[col] = row;
										pos_d[col]    = 3'd0;
									end
								end else begin
									pads_d[idx]    = 1'b1;
									pending_d[col] = row;
									if (!running_q[col]) begin
										armed_d[col] = 1'b1;
									end else begin
										rhythm_d[col] = row;
										pos_d[col]    = 3'd0;
									end
								end
							end
							evrts_pkg::PAGE_RHYTHM: begin
								bits_d[col][~row] = ~bits_q[col][~row];
							end
							evrts_pkg::PAGE_LENGTH: begin
								len_d[col] = new_len;
								if (running_q[col] && ({1'b0, pos_q[col]} >= new_len)) begin
									pos_d[col] = 3'd0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				evrts_pkg::KIND_PAGE: begin
					if (item.page_choice <= evrts_pkg::PAGE_LENGTH) begin
						page_d = item.page_choice;
					end
				end
				evrts_pkg::KIND_LATCH: begin
					latch_d = !latch_q;
					pads_d  = '0;
					if (latch_q) begin
						running_d = '0;
						armed_d   = '0;
						pos_d     = '0;
					end
				end
				evrts_pkg::KIND_INACTIVE: begin
					pads_d = '0;
					if (!latch_q) begin
						running_d = '0;
						armed_d   = '0;
						pos_d     = '0;
					end
				end
				default: begin
				end
			endcase
		end
		result.latch_on = latch_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_divide_q <= 7'd1;
		end else if (cfg_we) begin
			clock_divide_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_count_q <= '0;
			bits_q      <= evrts_pkg::DEFAULT_RHYTHMS;
			len_q       <= {8{4'd8}};
			running_q   <= '0;
			armed_q     <= '0;
			rhythm_q    <= '0;
			pos_q       <= '0;
			pending_q   <= '0;
			pads_q      <= '0;
			latch_q     <= 1'b0;
			page_q      <= evrts_pkg::PAGE_PLAY;
		end else begin
			div_count_q <= div_count_d;
			bits_q      <= bits_d;
			len_q       <= len_d;
			running_q   <= running_d;
			armed_q     <= armed_d;
			rhythm_q    <= rhythm_d;
			pos_q       <= pos_d;
			pending_q   <= pending_d;
			pads_q      <= pads_d;
			latch_q     <= latch_d;
			page_q      <= page_d;
		end
	end

	`ASSERT_IMPLIES(a_run_arm_excl, clk, arst_n, 1'b1, (running_q & armed_q) == 8'd0)
	`ASSERT_IMPLIES(a_quiet_non_tick, clk, arst_n, advance && (item.kind != evrts_pkg::KIND_TICK), (result.trigger_mask == 8'd0) && !result.step_taken)
	`ASSERT_NEXT(a_div_clear, clk, arst_n, advance && result.step_taken, div_count_q == 6'd0)

endmodule

[hdl/eight_voice_rhythm_trigger_sequencer.sv]
// channel   signals                                             dir
// input     in_valid in_ready kind pad_row pad_column           in
//           pad_pressed page_choice
// result    out_valid out_ready trigger_mask step_taken latch_on out
// config    cfg_we cfg_wdata (clock_divide)                     in
//
// one word per cycle sustained while out_ready is high: a word enters the
// input register, the whole state update runs on advance and lands in the
// result register; out_valid rises as the word lands there
// a stalled result holds the core; the input register still takes one word
// reset (arst_n low) restores the default rhythms, lengths of 8, latch off
`include "assert_macros.svh"

module eight_voice_rhythm_trigger_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] kind,
	input  logic [2:0] pad_row,
	input  logic [2:0] pad_column,
	input  logic       pad_pressed,
	input  logic [1:0] page_choice,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] trigger_mask,
	output logic       step_taken,
	output logic       latch_on
);

	evrts_pkg::item_t   item_s1;
	logic               valid_s1;
	evrts_pkg::result_t res_s2;
	evrts_pkg::result_t res_next;
	logic               valid_s2;
	logic               advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{kind: kind, pad_row: pad_row, pad_column: pad_column,
				pad_pressed: pad_pressed, page_choice: page_choice};
		end
	end

	evrts_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.item      (item_s1),
		.result    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid    = valid_s2;
	assign trigger_mask = res_s2.trigger_mask;
	assign step_taken   = res_s2.step_taken;
	assign latch_on     = res_s2.latch_on;

	`ASSERT_IMPLIES(a_no_overrun, clk, arst_n, valid_s1 && valid_s2 && !out_ready, !in_ready && !advance)
	`ASSERT_NEXT(a_result_from_core, clk, arst_n, !valid_s2 && !advance, !valid_s2)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

endmodule
